// File: rtl/core/sms_pkg.sv
// Shared types and constants for the sample mean / standard deviation block.
package sms_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 11;
  localparam int SUM_W    = 26;
  localparam int SQ_W     = 42;
  localparam int PROD_W   = 32;
  localparam int FRAC_W   = 8;
  localparam int OUT_W    = 24;

  // Datapath widths of the shared unit
  localparam int ACC_W    = 53;  // holds n*sumsq and the variance numerator
  localparam int DEN_W    = 20;  // n*(n-1) for n up to 1024
  localparam int DSH_W    = DEN_W + 1;
  localparam int Q_W      = 48;  // scaled variance quotient
  localparam int STEP_W   = 7;

  // Set size limits
  localparam logic [CNT_W-1:0] SET_SIZE_MIN   = 11'd10;
  localparam logic [CNT_W-1:0] SET_SIZE_MAX   = 11'd1024;
  localparam logic [CNT_W-1:0] SET_SIZE_RESET = 11'd200;

  // Iteration counts per phase, loaded as count minus one
  localparam logic [STEP_W-1:0] DEN_STEPS  = 7'd10;  // 11 multiplier bits
  localparam logic [STEP_W-1:0] MDIV_STEPS = 7'd33;  // 34 dividend bits
  localparam logic [STEP_W-1:0] MUL_STEPS  = 7'd10;  // 11 multiplier bits
  localparam logic [STEP_W-1:0] SUB_STEPS  = 7'd25;  // 26 multiplier bits
  localparam logic [STEP_W-1:0] VDIV_STEPS = 7'd68;  // 53 numerator + 16 fraction bits
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd23;  // 24 root bits

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DEN,
    ST_MDIV,
    ST_MUL,
    ST_SUB,
    ST_VDIV,
    ST_SQRT,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/sample_mean_stddev.sv
// Per-set mean and sample standard deviation over unsigned depth samples.
//
// Input channel (in_valid/in_ready) carries one 16-bit sample and a restart
// flag per word. Each accepted word is folded into a count, a sum and a sum
// of squares in the cycle after it is taken, and the block takes no new
// word while it folds one in. When the count reaches the set size K (cfg
// register, clamped to 10..1024, reset value 200), a sequencer drives one
// shared 53-bit add/subtract unit through: n*(n-1), mean division,
// n*sumsq, minus sum^2, variance division with 16 fraction bits and an
// integer square root. A closing word thus keeps the block busy through
// every phase before out_valid rises; those iterations through the shared
// adder set the rate.
// Results go out on out_valid/out_ready from an output register; the block
// keeps taking samples while a result waits, and holds a new result in the
// sequencer until the old one is taken. Restart clears the set in progress
// before the word is counted. Synchronous reset clears the accumulators,
// the output valid flag and loads the default set size.
module sample_mean_stddev (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sms_pkg::OUT_W-1:0]  out_mean_fixed,
  output logic [sms_pkg::OUT_W-1:0]  out_stddev_fixed,
  input  logic                       cfg_wr_en,
  input  logic [sms_pkg::CNT_W-1:0]  cfg_wr_data
);

  sms_pkg::state_t state_r, state_nxt;

  // Configuration and accumulators
  logic [sms_pkg::CNT_W-1:0]    set_size_r;
  logic [sms_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [sms_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [sms_pkg::SQ_W-1:0]     sq_r, sq_nxt;

  // Captured input word
  logic [sms_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                         restart_r, restart_nxt;

  // Shared-unit working registers
  logic [sms_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [sms_pkg::ACC_W-1:0]    mcand_r, mcand_nxt;
  logic [sms_pkg::SUM_W-1:0]    mplier_r, mplier_nxt;
  logic [sms_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [sms_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [sms_pkg::Q_W-1:0]      q_r, q_nxt;
  logic [sms_pkg::Q_W-1:0]      rad_r, rad_nxt;
  logic [sms_pkg::Q_W-1:0]      root_r, root_nxt;
  logic [sms_pkg::Q_W-1:0]      bit_r, bit_nxt;
  logic [sms_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [sms_pkg::OUT_W-1:0]    mean_r, mean_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [sms_pkg::OUT_W-1:0]    out_mean_r, out_mean_nxt;
  logic [sms_pkg::OUT_W-1:0]    out_std_r, out_std_nxt;

  // Shared add/subtract unit
  logic                         alu_sub;
  logic [sms_pkg::ACC_W-1:0]    alu_a, alu_b;
  logic [sms_pkg::ACC_W:0]      alu_res;
  logic                         alu_ok;

  // Helpers
  logic [sms_pkg::CNT_W-1:0]    eff_k;
  logic [sms_pkg::PROD_W-1:0]   sample_sq;
  logic [sms_pkg::DSH_W-1:0]    div_shift;
  logic [sms_pkg::Q_W-1:0]      q_shift;
  logic [sms_pkg::CNT_W-1:0]    count_base;
  logic [sms_pkg::SUM_W-1:0]    sum_base;
  logic [sms_pkg::SQ_W-1:0]     sq_base;
  logic                         last_step;

  assign in_ready         = (state_r == sms_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_mean_fixed   = out_mean_r;
  assign out_stddev_fixed = out_std_r;

  // Clamp the configured set size
  always_comb begin
    if (set_size_r < sms_pkg::SET_SIZE_MIN) begin
      eff_k = sms_pkg::SET_SIZE_MIN;
    end else if (set_size_r > sms_pkg::SET_SIZE_MAX) begin
      eff_k = sms_pkg::SET_SIZE_MAX;
    end else begin
      eff_k = set_size_r;
    end
  end

  assign sample_sq = {{(sms_pkg::PROD_W-sms_pkg::SAMPLE_W){1'b0}}, sample_r} *
                     {{(sms_pkg::PROD_W-sms_pkg::SAMPLE_W){1'b0}}, sample_r};

  // Division: partial remainder with next dividend bit; quotient shift
  assign div_shift = {rem_r, acc_r[sms_pkg::ACC_W-1]};
  assign q_shift   = {q_r[sms_pkg::Q_W-2:0], alu_ok};
  assign last_step = (step_r == '0);

  // Operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      sms_pkg::ST_DEN, sms_pkg::ST_MUL: begin
        alu_a = acc_r;
        alu_b = mplier_r[0] ? mcand_r : '0;
      end
      sms_pkg::ST_SUB: begin
        alu_a   = acc_r;
        alu_b   = mplier_r[0] ? mcand_r : '0;
        alu_sub = 1'b1;
      end
      sms_pkg::ST_MDIV: begin
        alu_a   = {{(sms_pkg::ACC_W-sms_pkg::DSH_W){1'b0}}, div_shift};
        alu_b   = {{(sms_pkg::ACC_W-sms_pkg::CNT_W){1'b0}}, count_r};
        alu_sub = 1'b1;
      end
      sms_pkg::ST_VDIV: begin
        alu_a   = {{(sms_pkg::ACC_W-sms_pkg::DSH_W){1'b0}}, div_shift};
        alu_b   = {{(sms_pkg::ACC_W-sms_pkg::DEN_W){1'b0}}, den_r};
        alu_sub = 1'b1;
      end
      sms_pkg::ST_SQRT: begin
        alu_a   = {{(sms_pkg::ACC_W-sms_pkg::Q_W){1'b0}}, rad_r};
        alu_b   = {{(sms_pkg::ACC_W-sms_pkg::Q_W){1'b0}}, root_r | bit_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // One adder; in subtract mode the carry out means no borrow
  assign alu_res = {1'b0, alu_a} + {1'b0, alu_b ^ {sms_pkg::ACC_W{alu_sub}}} +
                   {{sms_pkg::ACC_W{1'b0}}, alu_sub};
  assign alu_ok  = alu_res[sms_pkg::ACC_W];

  // Accumulator bases after an optional restart
  assign count_base = restart_r ? '0 : count_r;
  assign sum_base   = restart_r ? '0 : sum_r;
  assign sq_base    = restart_r ? '0 : sq_r;

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    sample_nxt    = sample_r;
    restart_nxt   = restart_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    step_nxt      = step_r;
    mean_nxt      = mean_r;
    out_mean_nxt  = out_mean_r;
    out_std_nxt   = out_std_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      sms_pkg::ST_IDLE: begin
        if (in_valid) begin
          sample_nxt  = in_sample;
          restart_nxt = in_restart;
          state_nxt   = sms_pkg::ST_ACC;
        end
      end

      // Fold the word into the running set
      sms_pkg::ST_ACC: begin
        count_nxt = count_base + 1'b1;
        sum_nxt   = sum_base + {{(sms_pkg::SUM_W-sms_pkg::SAMPLE_W){1'b0}}, sample_r};
        sq_nxt    = sq_base + {{(sms_pkg::SQ_W-sms_pkg::PROD_W){1'b0}}, sample_sq};
        if (count_nxt >= eff_k) begin
          acc_nxt    = '0;
          mcand_nxt  = {{(sms_pkg::ACC_W-sms_pkg::CNT_W){1'b0}}, count_nxt};
          mplier_nxt = {{(sms_pkg::SUM_W-sms_pkg::CNT_W){1'b0}}, count_nxt - 1'b1};
          step_nxt   = sms_pkg::DEN_STEPS;
          state_nxt  = sms_pkg::ST_DEN;
        end else begin
          state_nxt = sms_pkg::ST_IDLE;
        end
      end

      // Shift-add multiply steps (shift-subtract in the sub phase); den phase ends by loading the mean division
      sms_pkg::ST_DEN, sms_pkg::ST_MUL, sms_pkg::ST_SUB: begin
        acc_nxt    = alu_res[sms_pkg::ACC_W-1:0];
        mcand_nxt  = {mcand_r[sms_pkg::ACC_W-2:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[sms_pkg::SUM_W-1:1]};
        step_nxt   = step_r - 1'b1;
        if (last_step) begin
          case (state_r)
            sms_pkg::ST_DEN: begin
              den_nxt   = alu_res[sms_pkg::DEN_W-1:0];
              acc_nxt   = {sum_r, {(sms_pkg::ACC_W-sms_pkg::SUM_W){1'b0}}};
              rem_nxt   = '0;
              q_nxt     = '0;
              step_nxt  = sms_pkg::MDIV_STEPS;
              state_nxt = sms_pkg::ST_MDIV;
            end
            sms_pkg::ST_MUL: begin
              mcand_nxt  = {{(sms_pkg::ACC_W-sms_pkg::SUM_W){1'b0}}, sum_r};
              mplier_nxt = sum_r;
              step_nxt   = sms_pkg::SUB_STEPS;
              state_nxt  = sms_pkg::ST_SUB;
            end
            default: begin
              rem_nxt   = '0;
              q_nxt     = '0;
              step_nxt  = sms_pkg::VDIV_STEPS;
              state_nxt = sms_pkg::ST_VDIV;
            end
          endcase
        end
      end

      // Restoring division, one quotient bit per cycle
      sms_pkg::ST_MDIV, sms_pkg::ST_VDIV: begin
        rem_nxt  = alu_ok ? alu_res[sms_pkg::DEN_W-1:0] : div_shift[sms_pkg::DEN_W-1:0];
        q_nxt    = q_shift;
        acc_nxt  = {acc_r[sms_pkg::ACC_W-2:0], 1'b0};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          if (state_r == sms_pkg::ST_MDIV) begin
            mean_nxt   = q_shift[sms_pkg::OUT_W-1:0];
            acc_nxt    = '0;
            mcand_nxt  = {{(sms_pkg::ACC_W-sms_pkg::SQ_W){1'b0}}, sq_r};
            mplier_nxt = {{(sms_pkg::SUM_W-sms_pkg::CNT_W){1'b0}}, count_r};
            step_nxt   = sms_pkg::MUL_STEPS;
            state_nxt  = sms_pkg::ST_MUL;
          end else begin
            rad_nxt   = q_shift;
            root_nxt  = '0;
            bit_nxt   = {2'b01, {(sms_pkg::Q_W-2){1'b0}}};
            step_nxt  = sms_pkg::SQRT_STEPS;
            state_nxt = sms_pkg::ST_SQRT;
          end
        end
      end

      // Digit-by-digit integer square root
      sms_pkg::ST_SQRT: begin
        if (alu_ok) begin
          rad_nxt  = alu_res[sms_pkg::Q_W-1:0];
          root_nxt = {1'b0, root_r[sms_pkg::Q_W-1:1]} | bit_r;
        end else begin
          root_nxt = {1'b0, root_r[sms_pkg::Q_W-1:1]};
        end
        bit_nxt  = {2'b00, bit_r[sms_pkg::Q_W-1:2]};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          state_nxt = sms_pkg::ST_OUT;
        end
      end

      // Hand the result to the output register once it is free
      sms_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_std_nxt   = root_r[sms_pkg::OUT_W-1:0];
          count_nxt     = '0;
          sum_nxt       = '0;
          sq_nxt        = '0;
          state_nxt     = sms_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sms_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r  <= sms_pkg::SET_SIZE_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        set_size_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    restart_r  <= restart_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    rad_r      <= rad_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    step_r     <= step_nxt;
    mean_r     <= mean_nxt;
    out_mean_r <= out_mean_nxt;
    out_std_r  <= out_std_nxt;
  end

endmodule

// File: sim/sample_mean_stddev_tb.sv
// Self-checking testbench for sample_mean_stddev: per-set mean and deviation checks.
`timescale 1ns / 100ps

module sample_mean_stddev_tb;

  typedef struct {
    logic [sms_pkg::SAMPLE_W-1:0] sample;
    logic                         restart;
  } word_t;

  typedef struct {
    logic [sms_pkg::OUT_W-1:0] mean;
    logic [sms_pkg::OUT_W-1:0] stddev;
  } stats_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [sms_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                         in_restart = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [sms_pkg::OUT_W-1:0]    out_mean_fixed;
  logic [sms_pkg::OUT_W-1:0]    out_stddev_fixed;
  logic                         cfg_wr_en = 1'b0;
  logic [sms_pkg::CNT_W-1:0]    cfg_wr_data = '0;

  // Pending words, expected statistics, and the predictor's own state
  word_t                     sample_queue[$];
  stats_t                    stats_due[$];
  logic [sms_pkg::CNT_W-1:0] set_size_q = sms_pkg::SET_SIZE_RESET;
  logic [sms_pkg::CNT_W-1:0] acc_count = '0;
  logic [sms_pkg::SUM_W-1:0] acc_sum = '0;
  logic [sms_pkg::SQ_W-1:0]  acc_sq = '0;
  logic                      calm = 1'b0;
  int                        errors = 0;
  int                        queued_total = 0;

  sample_mean_stddev dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_fixed   (out_mean_fixed),
    .out_stddev_fixed (out_stddev_fixed),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Floor of the square root, built up one root bit at a time
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted word into the running set; queue the statistics on completion
  function automatic void fold_sample(word_t w);
    logic [63:0]  k;
    logic [63:0]  n;
    logic [63:0]  sum64;
    logic [63:0]  sq64;
    logic [63:0]  sq_term;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [63:0]  mean;
    logic [63:0]  root;
    stats_t       st;
    if (w.restart) begin
      acc_count = '0;
      acc_sum   = '0;
      acc_sq    = '0;
    end
    sq_term   = 64'(w.sample) * 64'(w.sample);
    acc_count = acc_count + 1'b1;
    acc_sum   = acc_sum + {{(sms_pkg::SUM_W-sms_pkg::SAMPLE_W){1'b0}}, w.sample};
    acc_sq    = acc_sq + sq_term[sms_pkg::SQ_W-1:0];
    k = 64'(set_size_q);
    if (k < 64'(sms_pkg::SET_SIZE_MIN)) k = 64'(sms_pkg::SET_SIZE_MIN);
    if (k > 64'(sms_pkg::SET_SIZE_MAX)) k = 64'(sms_pkg::SET_SIZE_MAX);
    if (64'(acc_count) < k) return;
    n     = 64'(acc_count);
    sum64 = 64'(acc_sum);
    sq64  = 64'(acc_sq);
    mean  = (sum64 << sms_pkg::FRAC_W) / n;
    num   = 128'(n * sq64) - 128'(sum64 * sum64);
    den   = 128'(n * (n - 1));
    q     = (num << (2 * sms_pkg::FRAC_W)) / den;
    root  = floor_root(q[63:0]);
    st.mean   = mean[sms_pkg::OUT_W-1:0];
    st.stddev = root[sms_pkg::OUT_W-1:0];
    stats_due.push_back(st);
    acc_count = '0;
    acc_sum   = '0;
    acc_sq    = '0;
  endfunction

  // Input driver: predicts on acceptance, then presents the next word or idles
  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        w.sample  = in_sample;
        w.restart = in_restart;
        fold_sample(w);
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          w = sample_queue.pop_front();
          in_valid   <= 1'b1;
          in_sample  <= w.sample;
          in_restart <= w.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, compare against the oldest expectation
  always @(posedge clk) begin
    stats_t st;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          $error("unexpected result word: mean_fixed %0d stddev_fixed %0d",
                 out_mean_fixed, out_stddev_fixed);
          errors++;
        end else begin
          st = stats_due.pop_front();
          if (out_mean_fixed !== st.mean) begin
            $error("mean_fixed: expected %0d, actual %0d", st.mean, out_mean_fixed);
            errors++;
          end
          if (out_stddev_fixed !== st.stddev) begin
            $error("stddev_fixed: expected %0d, actual %0d", st.stddev, out_stddev_fixed);
            errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 23);
    end
  end

  task automatic push_word(logic [sms_pkg::SAMPLE_W-1:0] s, logic r);
    word_t w;
    w.sample  = s;
    w.restart = r;
    sample_queue.push_back(w);
    queued_total++;
  endtask

  // Random samples in shifting styles: uniform, extremes, constant, narrow spread
  task automatic queue_random(int count, int restart_pct);
    int                           style;
    int unsigned                  rnd;
    logic [sms_pkg::SAMPLE_W-1:0] base;
    logic [sms_pkg::SAMPLE_W:0]   near;
    logic [sms_pkg::SAMPLE_W-1:0] s;
    style = $urandom_range(0, 3);
    rnd   = $urandom_range(0, 65535);
    base  = rnd[sms_pkg::SAMPLE_W-1:0];
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        style = $urandom_range(0, 3);
        rnd   = $urandom_range(0, 65535);
        base  = rnd[sms_pkg::SAMPLE_W-1:0];
      end
      case (style)
        0: begin
          rnd = $urandom_range(0, 65535);
          s   = rnd[sms_pkg::SAMPLE_W-1:0];
        end
        1: s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        2: s = base;
        default: begin
          rnd  = $urandom_range(0, 255);
          near = {1'b0, base} + rnd[sms_pkg::SAMPLE_W:0];
          s = near[sms_pkg::SAMPLE_W] ? 16'hFFFF : near[sms_pkg::SAMPLE_W-1:0];
        end
      endcase
      push_word(s, $urandom_range(1, 100) <= restart_pct);
    end
  endtask

  // Wait for the block to drain, then let any sequencer work finish
  task automatic settle();
    @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || stats_due.size() != 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_size(logic [sms_pkg::CNT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    set_size_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    logic [sms_pkg::CNT_W-1:0] k;
    int unsigned               kv;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Size below ten saturates; restart mid-set; restart on the word that would close the set
    write_size(11'd0);
    push_word(16'h0000, 1'b0);
    push_word(16'hFFFF, 1'b1);
    repeat (9) push_word(16'hFFFF, 1'b0);
    repeat (9) push_word(16'hFFFF, 1'b0);
    push_word(16'h0000, 1'b1);
    for (int i = 0; i < 9; i++) push_word((i % 2) ? 16'h0000 : 16'hFFFF, 1'b0);
    settle();

    // Largest set, no idling on either side
    write_size(sms_pkg::SET_SIZE_MAX);
    calm = 1'b1;
    queue_random(1024, 0);
    settle();
    calm = 1'b0;

    // Oversized register saturates; then lowered mid-set so the next word closes it
    write_size(11'h7FF);
    queue_random(30, 0);
    settle();
    write_size(11'd3);
    queue_random(40, 3);
    settle();

    // Random phases with mostly small sets
    while (queued_total < 1650) begin
      kv = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 9) : $urandom_range(10, 40);
      k  = kv[sms_pkg::CNT_W-1:0];
      write_size(k);
      queue_random($urandom_range(20, 90), 3);
      settle();
    end

    if (stats_due.size() != 0) begin
      $error("results missing: %0d still expected", stats_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
